// ----- rtl/core/mpu_region_table_top_assert.svh -----
// Assertion macros for the MPU region table.
// Included by the top level; needs a clock named clock and a reset named reset in scope.
`ifndef MPU_REGION_TABLE_TOP_ASSERT_SVH
`define MPU_REGION_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mpu region table check failed");

// Next-cycle implication, checked outside reset.
`define MPU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mpu region table check failed");

`endif

// ----- rtl/core/mpu_rt_pkg.sv -----
// Shared types, constants and helper functions for the MPU region table.
// No dependencies; used by mpu_rt_cmp and mpu_region_table_top.
package mpu_rt_pkg;

   // Defaults for the top-level parameters.
   localparam int NUM_REGIONS_DEF     = 8;
   localparam int MIN_REGION_BITS_DEF = 8;

   // Smallest region exponent the RBAR layout allows.
   localparam int ALIGN_BITS = 5;

   // Largest region exponent.
   localparam logic [4:0] MAX_REGION_BITS = 5'd31;

   // Operation codes of the request channel.
   localparam logic OP_CONFIG = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // Reciprocal of three for the scaled-size division.
   localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

   // Mask that clears the low address bits that RBAR does not hold.
   localparam logic [31:0] RBAR_ADDR_MASK = 32'hFFFF_FFE0;

   // Operands of the shared compare unit.
   typedef struct packed {
      logic [31:0] a0;
      logic [31:0] b0;
      logic [31:0] a1;
      logic [31:0] b1;
   } cmp_req_type;

   // Results of the shared compare unit.
   typedef struct packed {
      logic ge0;
      logic ge1;
   } cmp_rsp_type;

   // Map the access code onto the RASR AP field; reserved codes give no access.
   function automatic logic [2:0] ap_of_access(input logic [2:0] acc);
      logic [2:0] ap;
      case (acc)
         3'd1:    ap = 3'd5;
         3'd2:    ap = 3'd6;
         3'd3:    ap = 3'd1;
         3'd4:    ap = 3'd2;
         3'd5:    ap = 3'd3;
         default: ap = 3'd0;
      endcase
      return ap;
   endfunction

endpackage

// ----- rtl/core/mpu_rt_cmp.sv -----
// Shared unsigned compare unit of the MPU region table.
// Depends on mpu_rt_pkg for the operand and result structs.
module mpu_rt_cmp (
   input  mpu_rt_pkg::cmp_req_type cmp_req,
   output mpu_rt_pkg::cmp_rsp_type cmp_rsp
);

   // Two independent magnitude compares: range low/high bound or size search.
   always_comb begin
      cmp_rsp.ge0 = (cmp_req.a0 >= cmp_req.b0);
      cmp_rsp.ge1 = (cmp_req.a1 >= cmp_req.b1);
   end

endmodule

// ----- rtl/core/mpu_region_table_top.sv -----
// MPU region table: a small sequencer around one shared compare unit.
// Depends on mpu_rt_pkg, mpu_rt_cmp and mpu_region_table_top_assert.svh.
//
// A configure transfer runs from acceptance to the result register in these steps:
// ST_MUL scales the size by 8/6 with a reciprocal multiply, ST_SRCH runs
// a binary search for the region exponent on the shared comparator, ST_ALIGN
// aligns the base and ST_LIMIT builds the RASR/RBAR words and writes the table.
// A lookup transfer runs in ST_SCAN: the shared comparator
// checks one region per cycle from the highest slot down and stops at the
// first hit. The final step of either waits while the previous result is
// still held in a full output register. Only one transfer is in flight; a new
// request is taken while the previous result still waits in the output register.
module mpu_region_table_top #(
   parameter int NUM_REGIONS     = mpu_rt_pkg::NUM_REGIONS_DEF,
   parameter int MIN_REGION_BITS = mpu_rt_pkg::MIN_REGION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [2:0]  req_region_no,
   input  logic [31:0] req_address,
   input  logic [31:0] req_size_bytes,
   input  logic [2:0]  req_access_code,
   input  logic        req_executable,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic [2:0]  rsp_slot,
   output logic [31:0] rsp_region_base,
   output logic [31:0] rsp_region_limit,
   output logic [31:0] rsp_attr_word,
   output logic [31:0] rsp_base_word,
   output logic [2:0]  rsp_slot_access
);

   localparam int IDX_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(NUM_REGIONS - 1);
   localparam logic [4:0] NUM_REG_W = 5'(NUM_REGIONS);
   localparam logic [4:0] LIM_BITS =
      5'((MIN_REGION_BITS < mpu_rt_pkg::ALIGN_BITS) ? mpu_rt_pkg::ALIGN_BITS
                                                    : MIN_REGION_BITS);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_SRCH  = 6'b000100,
      ST_ALIGN = 6'b001000,
      ST_LIMIT = 6'b010000,
      ST_SCAN  = 6'b100000
   } state_type;

   // Sequencer and working registers.
   state_type        state_ff, state_in;
   logic [2:0]       region_ff, region_in;
   logic [31:0]      addr_ff, addr_in;
   logic [31:0]      size_ff, size_in;
   logic [2:0]       acc_ff, acc_in;
   logic             exe_ff, exe_in;
   logic [31:0]      scaled_ff, scaled_in;
   logic [4:0]       lo_ff, lo_in;
   logic [4:0]       hi_ff, hi_in;
   logic [4:0]       bits_ff, bits_in;
   logic [31:0]      base_ff, base_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_hit_ff, rsp_hit_in;
   logic [2:0]  rsp_slot_ff, rsp_slot_in;
   logic [31:0] rsp_base_ff, rsp_base_in;
   logic [31:0] rsp_limit_ff, rsp_limit_in;
   logic [31:0] rsp_attr_ff, rsp_attr_in;
   logic [31:0] rsp_rbar_ff, rsp_rbar_in;
   logic [2:0]  rsp_acc_ff, rsp_acc_in;

   // Region table; an entry without its valid bit reads as never hitting.
   logic [NUM_REGIONS-1:0] valid_ff;
   logic [31:0]            base_store_ff [NUM_REGIONS];
   logic [31:0]            limit_store_ff [NUM_REGIONS];
   logic [31:0]            attr_store_ff [NUM_REGIONS];
   logic [2:0]             access_store_ff [NUM_REGIONS];
   logic                   store_we;
   logic [IDX_W-1:0]       store_idx;
   logic [31:0]            store_limit;
   logic [31:0]            store_attr;

   // Datapath helpers.
   mpu_rt_pkg::cmp_req_type cmp_req;
   mpu_rt_pkg::cmp_rsp_type cmp_rsp;
   logic [63:0] prod;
   logic [31:0] size_x4;
   logic [4:0]  mid;
   logic [4:0]  bits_sel;
   logic [31:0] rsize;
   logic [31:0] rmask;
   logic [31:0] start;
   logic        out_free;
   logic        accept;
   logic        entry_hit;
   logic        in_range;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign in_range = ({2'b00, region_ff} < NUM_REG_W);

   // Size times 8/6 equals (size times 4, taken modulo 2^31) divided by 3.
   assign size_x4 = {1'b0, size_ff[28:0], 2'b00};
   assign prod    = size_x4 * mpu_rt_pkg::RECIP3;

   // Midpoint of the exponent search.
   assign mid = 5'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);

   // Region exponent clamped to the minimum, then the rounded-up start.
   assign bits_sel = (lo_ff < LIM_BITS) ? LIM_BITS : lo_ff;
   assign rsize    = 32'd1 << bits_sel;
   assign rmask    = rsize - 32'd1;
   assign start    = ((addr_ff & rmask) != 32'd0) ? ((addr_ff & ~rmask) + rsize) : addr_ff;

   // Operand selection for the shared compare unit.
   always_comb begin
      cmp_req = '0;
      if (state_ff == ST_SRCH) begin
         cmp_req.a0 = 32'd1 << mid;
         cmp_req.b0 = scaled_ff;
      end else if (state_ff == ST_SCAN) begin
         cmp_req.a0 = addr_ff;
         cmp_req.b0 = base_store_ff[idx_ff];
         cmp_req.a1 = addr_ff;
         cmp_req.b1 = limit_store_ff[idx_ff];
      end
   end

   mpu_rt_cmp u_cmp (
      .cmp_req (cmp_req),
      .cmp_rsp (cmp_rsp)
   );

   // Base at or below the address, address below the limit.
   assign entry_hit = valid_ff[idx_ff] && cmp_rsp.ge0 && !cmp_rsp.ge1;

   // Words of a configure, built in the last step.
   assign store_limit = base_ff + size_ff;
   assign store_attr  = {3'b000, !exe_ff, 1'b0, mpu_rt_pkg::ap_of_access(acc_ff),
                         18'd0, bits_ff - 5'd1, 1'b1};
   assign store_idx   = IDX_W'(region_ff);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      region_in    = region_ff;
      addr_in      = addr_ff;
      size_in      = size_ff;
      acc_in       = acc_ff;
      exe_in       = exe_ff;
      scaled_in    = scaled_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      bits_in      = bits_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_base_in  = rsp_base_ff;
      rsp_limit_in = rsp_limit_ff;
      rsp_attr_in  = rsp_attr_ff;
      rsp_rbar_in  = rsp_rbar_ff;
      rsp_acc_in   = rsp_acc_ff;
      store_we     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               region_in = req_region_no;
               addr_in   = req_address;
               size_in   = req_size_bytes;
               acc_in    = req_access_code;
               exe_in    = req_executable;
               idx_in    = TOP_IDX;
               state_in  = (req_opcode == mpu_rt_pkg::OP_CONFIG) ? ST_MUL : ST_SCAN;
            end
         end
         ST_MUL: begin
            scaled_in = {1'b0, prod[63:33]};
            lo_in     = 5'd0;
            hi_in     = mpu_rt_pkg::MAX_REGION_BITS;
            state_in  = ST_SRCH;
         end
         ST_SRCH: begin
            // Smallest exponent whose power of two covers the scaled size.
            if (cmp_rsp.ge0) begin
               hi_in = mid;
            end else begin
               lo_in = mid + 5'd1;
            end
            if (lo_in == hi_in) begin
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            bits_in  = bits_sel;
            base_in  = start & mpu_rt_pkg::RBAR_ADDR_MASK;
            state_in = ST_LIMIT;
         end
         ST_LIMIT: begin
            if (out_free) begin
               store_we     = in_range;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = in_range;
               rsp_slot_in  = region_ff;
               rsp_base_in  = base_ff;
               rsp_limit_in = store_limit;
               rsp_attr_in  = store_attr;
               rsp_rbar_in  = {base_ff[31:5], 1'b1, 1'b0, region_ff};
               rsp_acc_in   = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (entry_hit) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = 1'b1;
                  rsp_slot_in  = 3'(idx_ff);
                  rsp_base_in  = base_store_ff[idx_ff];
                  rsp_limit_in = limit_store_ff[idx_ff];
                  rsp_attr_in  = attr_store_ff[idx_ff];
                  rsp_rbar_in  = (base_store_ff[idx_ff] & mpu_rt_pkg::RBAR_ADDR_MASK) |
                                 {27'd0, 1'b1, 4'(idx_ff)};
                  rsp_acc_in   = access_store_ff[idx_ff];
                  state_in     = ST_IDLE;
               end
            end else if (idx_ff == '0) begin
               // No region holds the address: all result fields are zero.
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = 1'b0;
                  rsp_slot_in  = 3'd0;
                  rsp_base_in  = 32'd0;
                  rsp_limit_in = 32'd0;
                  rsp_attr_in  = 32'd0;
                  rsp_rbar_in  = 32'd0;
                  rsp_acc_in   = 3'd0;
                  state_in     = ST_IDLE;
               end
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (store_we) begin
            valid_ff[store_idx] <= 1'b1;
         end
      end
   end

   // Payload registers and table entries.
   always_ff @(posedge clock) begin
      region_ff    <= region_in;
      addr_ff      <= addr_in;
      size_ff      <= size_in;
      acc_ff       <= acc_in;
      exe_ff       <= exe_in;
      scaled_ff    <= scaled_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      bits_ff      <= bits_in;
      base_ff      <= base_in;
      idx_ff       <= idx_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_base_ff  <= rsp_base_in;
      rsp_limit_ff <= rsp_limit_in;
      rsp_attr_ff  <= rsp_attr_in;
      rsp_rbar_ff  <= rsp_rbar_in;
      rsp_acc_ff   <= rsp_acc_in;
      if (store_we) begin
         base_store_ff[store_idx]   <= base_ff;
         limit_store_ff[store_idx]  <= store_limit;
         attr_store_ff[store_idx]   <= store_attr;
         access_store_ff[store_idx] <= acc_ff;
      end
   end

   // Port drive.
   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_region_base  = rsp_base_ff;
   assign rsp_region_limit = rsp_limit_ff;
   assign rsp_attr_word    = rsp_attr_ff;
   assign rsp_base_word    = rsp_rbar_ff;
   assign rsp_slot_access  = rsp_acc_ff;

   // Checks on the sequencer and the result words.
`include "mpu_region_table_top_assert.svh"

   `MPU_ASSERT_NEXT(a_busy_after_accept, accept, !req_ready)
   `MPU_ASSERT_NOW(a_hit_enabled, rsp_valid && rsp_hit, rsp_attr_word[0] && rsp_base_word[4])
   `MPU_ASSERT_NOW(a_search_bounds, state_ff == ST_SRCH, lo_ff < hi_ff)

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the MPU region table: configures regions and probes addresses.
// Each transfer is checked against a predictor that keeps its own copy of the table.
// Depends on mpu_rt_pkg and mpu_region_table_top.
module tb_top;

   localparam int REGION_COUNT   = mpu_rt_pkg::NUM_REGIONS_DEF;
   localparam int RANDOM_ITEMS   = 550;
   localparam int STALL_MAX      = 13;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 20;

   // RASR and RBAR field positions.
   localparam int          XN_BIT     = 28;
   localparam int          AP_LSB     = 24;
   localparam int          SIZE_LSB   = 1;
   localparam logic [31:0] RBAR_VALID = 32'h0000_0010;

   // Access codes of the request and the AP values they map onto.
   typedef enum logic [2:0] {
      ACC_NONE, ACC_RO_NONE, ACC_RO_RO, ACC_RW_NONE,
      ACC_RW_RO, ACC_RW_RW, ACC_RESERVED, ACC_RESERVED_HI
   } access_type;

   localparam logic [2:0] AP_NO_ACCESS  = 3'd0;
   localparam logic [2:0] AP_PRIV_RW    = 3'd1;
   localparam logic [2:0] AP_PRIV_RW_RO = 3'd2;
   localparam logic [2:0] AP_FULL       = 3'd3;
   localparam logic [2:0] AP_PRIV_RO    = 3'd5;
   localparam logic [2:0] AP_READ_ONLY  = 3'd6;

   typedef struct packed {
      logic        opcode;
      logic [2:0]  region_no;
      logic [31:0] address;
      logic [31:0] size_bytes;
      logic [2:0]  access_code;
      logic        executable;
   } mpu_request_type;

   typedef struct packed {
      logic        hit;
      logic [2:0]  slot;
      logic [31:0] region_base;
      logic [31:0] region_limit;
      logic [31:0] attr_word;
      logic [31:0] base_word;
      logic [2:0]  slot_access;
   } mpu_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = mpu_rt_pkg::OP_CONFIG;
   logic [2:0]  req_region_no = 3'd0;
   logic [31:0] req_address = 32'd0;
   logic [31:0] req_size_bytes = 32'd0;
   logic [2:0]  req_access_code = ACC_NONE;
   logic        req_executable = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_hit;
   logic [2:0]  rsp_slot;
   logic [31:0] rsp_region_base;
   logic [31:0] rsp_region_limit;
   logic [31:0] rsp_attr_word;
   logic [31:0] rsp_base_word;
   logic [2:0]  rsp_slot_access;

   // Requests waiting to be driven and answers waiting to arrive.
   mpu_request_type pending_requests[$];
   mpu_answer_type  expected_answers[$];

   // Predictor copy of the region table.
   logic [31:0] table_base[REGION_COUNT];
   logic [31:0] table_limit[REGION_COUNT];
   logic [31:0] table_attr[REGION_COUNT];
   logic [2:0]  table_access[REGION_COUNT];

   // Region bounds as the stimulus generator expects them, used to aim lookups.
   logic [31:0] aim_base[REGION_COUNT];
   logic [31:0] aim_limit[REGION_COUNT];

   int   mismatches = 0;
   int   idle_cycles = 0;
   int   req_wait = 0;
   int   rsp_wait = 0;
   bit   req_burst = 1'b0;
   bit   rsp_burst = 1'b0;
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   mpu_region_table_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_region_no    (req_region_no),
      .req_address      (req_address),
      .req_size_bytes   (req_size_bytes),
      .req_access_code  (req_access_code),
      .req_executable   (req_executable),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_slot         (rsp_slot),
      .rsp_region_base  (rsp_region_base),
      .rsp_region_limit (rsp_region_limit),
      .rsp_attr_word    (rsp_attr_word),
      .rsp_base_word    (rsp_base_word),
      .rsp_slot_access  (rsp_slot_access)
   );

   always #1 clock = ~clock;

   // Translate an access code into the RASR AP field; reserved codes give no access.
   function automatic logic [2:0] access_to_ap(input logic [2:0] code);
      case (code)
         ACC_RO_NONE: return AP_PRIV_RO;
         ACC_RO_RO:   return AP_READ_ONLY;
         ACC_RW_NONE: return AP_PRIV_RW;
         ACC_RW_RO:   return AP_PRIV_RW_RO;
         ACC_RW_RW:   return AP_FULL;
         default:     return AP_NO_ACCESS;
      endcase
   endfunction

   // Size, align and encode a region from a configure request.
   function automatic mpu_answer_type region_from_request(input mpu_request_type rq);
      mpu_answer_type ans;
      logic [31:0] times8;
      logic [31:0] scaled;
      logic [31:0] span;
      logic [31:0] mask;
      logic [31:0] start;
      int          exp_bits;
      int          floor_bits;
      times8 = rq.size_bytes << 3;
      scaled = times8 / 32'd6;
      exp_bits = 0;
      if (scaled != 32'd0) begin
         while (exp_bits < 31 && (32'd1 << exp_bits) < scaled) exp_bits++;
      end
      floor_bits = (mpu_rt_pkg::MIN_REGION_BITS_DEF > mpu_rt_pkg::ALIGN_BITS) ?
                   mpu_rt_pkg::MIN_REGION_BITS_DEF : mpu_rt_pkg::ALIGN_BITS;
      if (exp_bits < floor_bits) exp_bits = floor_bits;
      if (exp_bits > 31) exp_bits = 31;
      span = 32'd1 << exp_bits;
      mask = span - 32'd1;
      // Round the start up to the region size; this may wrap past the top.
      start = rq.address;
      if ((start & mask) != 32'd0) start = (start & ~mask) + span;
      ans.region_base  = start & mpu_rt_pkg::RBAR_ADDR_MASK;
      ans.region_limit = ans.region_base + rq.size_bytes;
      ans.attr_word    = 32'(access_to_ap(rq.access_code)) << AP_LSB;
      if (!rq.executable) ans.attr_word[XN_BIT] = 1'b1;
      ans.attr_word[SIZE_LSB +: 5] = 5'(exp_bits - 1);
      ans.attr_word[0] = 1'b1;
      ans.base_word    = ans.region_base | RBAR_VALID | 32'(rq.region_no);
      ans.hit          = (int'(rq.region_no) < REGION_COUNT);
      ans.slot         = rq.region_no;
      ans.slot_access  = rq.access_code;
      return ans;
   endfunction

   // Scan the predictor table from the highest slot down for the probe address.
   function automatic mpu_answer_type lookup_answer(input logic [31:0] probe);
      mpu_answer_type ans;
      ans = '0;
      for (int k = REGION_COUNT - 1; k >= 0; k--) begin
         if (table_base[k] <= probe && probe < table_limit[k]) begin
            ans.hit          = 1'b1;
            ans.slot         = 3'(k);
            ans.region_base  = table_base[k];
            ans.region_limit = table_limit[k];
            ans.attr_word    = table_attr[k];
            ans.base_word    = (table_base[k] & mpu_rt_pkg::RBAR_ADDR_MASK) | RBAR_VALID |
                               32'(k);
            ans.slot_access  = table_access[k];
            return ans;
         end
      end
      return ans;
   endfunction

   function automatic bit field_differs(input string label, input logic [31:0] want,
                                        input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s differs, expected 0x%08h, actual 0x%08h", $time, label, want, got);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic mpu_request_type config_request(input logic [2:0] region,
                                                      input logic [31:0] addr,
                                                      input logic [31:0] size,
                                                      input logic [2:0] acc,
                                                      input logic exe);
      mpu_request_type rq;
      rq = '{mpu_rt_pkg::OP_CONFIG, region, addr, size, acc, exe};
      return rq;
   endfunction

   // Lookups carry random values in the fields that the block ignores.
   function automatic mpu_request_type lookup_request(input logic [31:0] probe);
      mpu_request_type rq;
      rq = '{mpu_rt_pkg::OP_LOOKUP, 3'($urandom_range(0, 7)), probe, $urandom,
             3'($urandom_range(0, 6)), 1'($urandom_range(0, 1))};
      return rq;
   endfunction

   task automatic queue_request(input mpu_request_type rq);
      mpu_answer_type region;
      if (rq.opcode == mpu_rt_pkg::OP_CONFIG) begin
         region = region_from_request(rq);
         if (region.hit) begin
            aim_base[rq.region_no]  = region.region_base;
            aim_limit[rq.region_no] = region.region_limit;
         end
      end
      pending_requests.push_back(rq);
   endtask

   // Pick a probe address inside, at the edge of, or just outside a stored region.
   function automatic logic [31:0] aimed_probe();
      int          k;
      int          pick;
      logic [31:0] span;
      k = $urandom_range(0, REGION_COUNT - 1);
      if (aim_limit[k] <= aim_base[k]) return $urandom;
      span = aim_limit[k] - aim_base[k];
      pick = $urandom_range(0, 9);
      case (pick)
         0:       return aim_base[k];
         1:       return aim_limit[k] - 32'd1;
         2:       return aim_limit[k];
         3:       return aim_base[k] - 32'd1;
         default: return aim_base[k] + ($urandom % span);
      endcase
   endfunction

   function automatic mpu_request_type random_config();
      logic [31:0] addr;
      logic [31:0] size;
      int          pick;
      pick = $urandom_range(0, 9);
      // Half of the regions land in one window so that they overlap.
      if (pick < 5) addr = 32'h2000_0000 + $urandom_range(0, 32'h3FFF);
      else if (pick < 8) addr = $urandom;
      else if (pick < 9) addr = 32'hFFFF_F000 | $urandom_range(0, 32'hFFF);
      else addr = 32'($urandom_range(0, 255)) << 8;
      pick = $urandom_range(0, 9);
      if (pick < 6) size = $urandom_range(0, 32'h3FF);
      else if (pick < 8) size = $urandom_range(0, 32'hFFFF);
      else if (pick < 9) size = 32'd1 << $urandom_range(0, 31);
      else size = $urandom;
      return config_request(3'($urandom_range(0, 7)), addr, size, 3'($urandom_range(0, 6)),
                            1'($urandom_range(0, 1)));
   endfunction

   function automatic int draw_wait(inout bit burst);
      if ($urandom_range(0, 29) == 0) burst = !burst;
      return burst ? 0 : $urandom_range(0, STALL_MAX);
   endfunction

   // Stimulus, reset and end of run.
   initial begin
      int pick;
      for (int k = 0; k < REGION_COUNT; k++) begin
         aim_base[k]  = 32'd0;
         aim_limit[k] = 32'd0;
      end

      // Empty table after reset, then corner cases of sizing and alignment.
      queue_request(lookup_request(32'h0000_0000));
      queue_request(lookup_request(32'hFFFF_FFFF));
      queue_request(config_request(3'd0, 32'h0000_0000, 32'h0000_0000, ACC_NONE, 1'b0));
      queue_request(lookup_request(32'h0000_0000));
      queue_request(config_request(3'd1, 32'h0000_1000, 32'h0000_0100, ACC_RO_NONE, 1'b1));
      queue_request(config_request(3'd2, 32'h0000_1001, 32'h0000_0080, ACC_RO_RO, 1'b0));
      queue_request(config_request(3'd3, 32'hFFFF_FF01, 32'h0000_0001, ACC_RW_NONE, 1'b1));
      queue_request(config_request(3'd4, 32'h1234_5678, 32'hFFFF_FFFF, ACC_RW_RO, 1'b0));
      queue_request(config_request(3'd5, 32'h8000_0000, 32'h2000_0000, ACC_RW_RW, 1'b1));
      queue_request(lookup_request(32'h0000_1000));
      queue_request(lookup_request(32'h0000_0000));
      queue_request(config_request(3'd6, 32'hFFFF_FFFF, 32'h7FFF_FFFF, ACC_RESERVED, 1'b0));
      queue_request(config_request(3'd7, 32'h0000_1080, 32'h0000_0040, ACC_RESERVED_HI, 1'b1));
      queue_request(lookup_request(32'h0000_1000));
      queue_request(lookup_request(32'h0000_10FF));
      queue_request(lookup_request(32'h0000_1100));
      queue_request(lookup_request(32'h0000_1080));
      queue_request(lookup_request(32'h8000_0000));
      queue_request(lookup_request(32'h9FFF_FFFF));
      queue_request(lookup_request(32'hA000_0000));
      queue_request(lookup_request(32'hFFFF_FFFF));

      // Random mix: configures, lookups aimed at stored regions, and stray probes.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) queue_request(random_config());
         else if (pick < 85) queue_request(lookup_request(aimed_probe()));
         else queue_request(lookup_request($urandom));
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid || expected_answers.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Request driver: holds each transfer until it is taken, then idles a random gap.
   always @(negedge clock) begin
      mpu_request_type rq;
      logic            next_valid;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_taken) req_wait = draw_wait(req_burst);
         if (req_wait > 0) begin
            req_wait--;
            next_valid = 1'b0;
         end else if (pending_requests.size() != 0) begin
            rq = pending_requests.pop_front();
            req_opcode      <= rq.opcode;
            req_region_no   <= rq.region_no;
            req_address     <= rq.address;
            req_size_bytes  <= rq.size_bytes;
            req_access_code <= rq.access_code;
            req_executable  <= rq.executable;
            next_valid = 1'b1;
         end else begin
            next_valid = 1'b0;
         end
      end
      req_valid <= next_valid;
   end

   // Response stall: after each transfer, ready drops for a random number of cycles.
   always @(negedge clock) begin
      if (rsp_taken) rsp_wait = draw_wait(rsp_burst);
      if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: checks each response, then predicts the answer of each accepted request.
   always @(posedge clock) begin
      mpu_request_type rq;
      mpu_answer_type  want;
      mpu_answer_type  got;
      bit              bad;
      req_taken <= !reset && req_valid && req_ready;
      rsp_taken <= !reset && rsp_valid && rsp_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_hit, rsp_slot, rsp_region_base, rsp_region_limit,
                    rsp_attr_word, rsp_base_word, rsp_slot_access};
            if (expected_answers.size() == 0) begin
               $display("%0t: result with nothing expected, expected none, actual slot %0d hit %0b",
                        $time, got.slot, got.hit);
               mismatches++;
            end else begin
               want = expected_answers.pop_front();
               bad = 1'b0;
               bad |= field_differs("hit", 32'(want.hit), 32'(got.hit));
               bad |= field_differs("slot", 32'(want.slot), 32'(got.slot));
               bad |= field_differs("region_base", want.region_base, got.region_base);
               bad |= field_differs("region_limit", want.region_limit, got.region_limit);
               bad |= field_differs("attr_word", want.attr_word, got.attr_word);
               bad |= field_differs("base_word", want.base_word, got.base_word);
               bad |= field_differs("slot_access", 32'(want.slot_access), 32'(got.slot_access));
               if (bad) mismatches++;
            end
         end
         if (req_valid && req_ready) begin
            rq = '{req_opcode, req_region_no, req_address, req_size_bytes,
                   req_access_code, req_executable};
            if (rq.opcode == mpu_rt_pkg::OP_CONFIG) begin
               want = region_from_request(rq);
               if (want.hit) begin
                  table_base[rq.region_no]   <= want.region_base;
                  table_limit[rq.region_no]  <= want.region_limit;
                  table_attr[rq.region_no]   <= want.attr_word;
                  table_access[rq.region_no] <= want.slot_access;
               end
            end else begin
               want = lookup_answer(rq.address);
            end
            expected_answers.push_back(want);
         end
      end else begin
         for (int k = 0; k < REGION_COUNT; k++) begin
            table_base[k]   <= 32'd0;
            table_limit[k]  <= 32'd0;
            table_attr[k]   <= 32'd0;
            table_access[k] <= ACC_NONE;
         end
      end
   end

   // Watchdog: ends the run if work is outstanding and no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (pending_requests.size() == 0 && !req_valid && expected_answers.size() == 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mpu_rt_pkg.sv
rtl/core/mpu_rt_cmp.sv
rtl/core/mpu_region_table_top.sv
dv/tb_top.sv
